FILE: design/srtl_pkg.sv
package srtl_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Command queue between the front and the engine.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Stream widths.
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_MATCH    = 2'd2,
    STAT_NOMATCH  = 2'd3
  } status_t;

  // One decoded input transaction.
  typedef struct packed {
    op_t         op;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [23:0] metric;
    logic [15:0] route_tag;
    logic        entry_valid;
  } cmd_t;

  // One stored route as held in the table memory.
  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [23:0] metric;
    logic [31:0] mask;
    logic [31:0] dest;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  // True when route a sorts strictly ahead of route b: wider mask value first,
  // then lower destination, then lower metric.
  function automatic logic orders_before(input logic [31:0] ma, input logic [31:0] da,
                                         input logic [23:0] ka, input logic [31:0] mb,
                                         input logic [31:0] db, input logic [23:0] kb);
    if (ma != mb) begin
      return ma > mb;
    end else if (da != db) begin
      return da < db;
    end else begin
      return ka < kb;
    end
  endfunction

endpackage

FILE: design/srtl_ram.sv
module srtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/srtl_front.sv
module srtl_front import srtl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  // The stage takes a transaction whenever it is empty or being emptied.
  assign in_tready = !vld_r || cmd_ready;

  // Unpack the transaction and name its kind.
  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
      if (in_tvalid) begin
        cmd_nxt.op          = in_tuser ? OP_LOOKUP : OP_INSERT;
        cmd_nxt.address     = in_tdata[31:0];
        cmd_nxt.netmask     = in_tdata[63:32];
        cmd_nxt.metric      = in_tdata[87:64];
        cmd_nxt.route_tag   = in_tdata[103:88];
        cmd_nxt.entry_valid = in_tdata[104];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule

FILE: design/srtl_cmdq.sv
module srtl_cmdq import srtl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] fill_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = fill_r != CMDQ_CNT_W'(CMDQ_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/srtl_engine.sv
module srtl_engine import srtl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_INS,
    S_INS_HEAD,
    S_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cur_r, cur_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  status_t                res_stat_r, res_stat_nxt;
  logic [15:0]            res_tag_r, res_tag_nxt;
  logic [23:0]            res_met_r, res_met_nxt;
  logic [31:0]            res_mask_r, res_mask_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t                out_stat_r, out_stat_nxt;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  route_t                 wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [ROUTE_W-1:0]     rd_raw;
  route_t                 ent;
  route_t                 new_ent;
  logic [CNT_W-1:0]       count_m1;
  logic [IDX_W-1:0]       last_idx;
  logic                   hit;
  logic                   goes_first;

  // Route table memory, one entry per sorted position.
  srtl_ram #(
    .WIDTH(ROUTE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  assign ent      = route_t'(rd_raw);
  assign count_m1 = count_r - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];

  // The route carried by the command being worked on.
  always_comb begin
    new_ent.valid  = cur_r.entry_valid;
    new_ent.tag    = cur_r.route_tag;
    new_ent.metric = cur_r.metric;
    new_ent.mask   = cur_r.netmask;
    new_ent.dest   = cur_r.address;
  end

  // Match test for a lookup and order test for an insert, on the entry just read.
  assign hit        = ent.valid && (((cur_r.address ^ ent.dest) & ent.mask) == 32'd0);
  assign goes_first = orders_before(cur_r.netmask, cur_r.address, cur_r.metric,
                                    ent.mask, ent.dest, ent.metric);

  // Sequencer: lookups scan upwards one entry a cycle; inserts scan downwards,
  // moving each later entry up one place until the slot is found.
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    res_stat_nxt = res_stat_r;
    res_tag_nxt  = res_tag_r;
    res_met_nxt  = res_met_r;
    res_mask_nxt = res_mask_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_stat_nxt = out_stat_r;
    cmd_ready    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = idx_r + 1'b1;
    wr_data      = ent;
    rd_addr      = idx_r;

    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_nxt      = cmd;
          res_tag_nxt  = '0;
          res_met_nxt  = '0;
          res_mask_nxt = '0;
          if (cmd.op == OP_LOOKUP) begin
            if (count_r == '0) begin
              res_stat_nxt = STAT_NOMATCH;
              state_nxt    = S_RESP;
            end else begin
              idx_nxt   = '0;
              rd_addr   = '0;
              state_nxt = S_LOOK;
            end
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            res_stat_nxt = STAT_FULL;
            state_nxt    = S_RESP;
          end else if (count_r == '0) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data.valid  = cmd.entry_valid;
            wr_data.tag    = cmd.route_tag;
            wr_data.metric = cmd.metric;
            wr_data.mask   = cmd.netmask;
            wr_data.dest   = cmd.address;
            count_nxt      = count_r + 1'b1;
            res_stat_nxt   = STAT_INSERTED;
            state_nxt      = S_RESP;
          end else begin
            idx_nxt   = last_idx;
            rd_addr   = last_idx;
            state_nxt = S_INS;
          end
        end
      end

      S_LOOK: begin
        if (hit) begin
          res_stat_nxt = STAT_MATCH;
          res_tag_nxt  = ent.tag;
          res_met_nxt  = ent.metric;
          res_mask_nxt = ent.mask;
          state_nxt    = S_RESP;
        end else if (idx_r == last_idx) begin
          res_stat_nxt = STAT_NOMATCH;
          state_nxt    = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end

      S_INS: begin
        wr_en = 1'b1;
        if (goes_first) begin
          // The stored entry sorts after the new route: move it up one place.
          wr_data = ent;
          if (idx_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            idx_nxt = idx_r - 1'b1;
            rd_addr = idx_r - 1'b1;
          end
        end else begin
          wr_data      = new_ent;
          count_nxt    = count_r + 1'b1;
          res_stat_nxt = STAT_INSERTED;
          state_nxt    = S_RESP;
        end
      end

      S_INS_HEAD: begin
        wr_en        = 1'b1;
        wr_addr      = '0;
        wr_data      = new_ent;
        count_nxt    = count_r + 1'b1;
        res_stat_nxt = STAT_INSERTED;
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_stat_nxt = res_stat_r;
          out_data_nxt = {res_mask_r, res_met_r, res_tag_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    res_stat_r <= res_stat_nxt;
    res_tag_r  <= res_tag_nxt;
    res_met_r  <= res_met_nxt;
    res_mask_r <= res_mask_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

FILE: design/sorted_route_table_lpm.sv
// Channel | Direction | tdata (lowest bit up)                              | tuser
// in_     | slave     | address, netmask, metric, route_tag, entry_valid  | operation
// out_    | master    | match_tag, match_metric, match_netmask            | status
//
// A lookup reads entries in order from the first up to and including the first match,
// or through all stored entries when nothing matches, at one table read a cycle.
// An insert moves each entry that sorts after the new route up one place to open its
// slot; an insert into an empty table writes the route straight into the first entry.
// A full-table insert or an empty-table lookup answers without reading the table.
// Reset clears the route count; table contents need no clearing pass.
// A short command queue keeps the input side taking transactions, until the queue
// fills, while the engine works or the output register waits to be taken.
module sorted_route_table_lpm import srtl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // address, netmask, metric, route_tag, entry_valid
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // match_tag, match_metric, match_netmask
  output logic [1:0]             out_tuser   // status
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Front: takes and decodes input transactions.
  srtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  // Queue between front and engine.
  srtl_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_cmd  (f_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd)
  );

  // Engine: sorted insert and longest-prefix lookup over the table memory.
  srtl_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
